FILE: rtl/crc16_length_framed_packet_receiver_top_defines.svh
// Assertion macros for the packet receiver RTL; plp_parser is the only file that includes them.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CRC16_LENGTH_FRAMED_PACKET_RECEIVER_TOP_DEFINES_SVH
`define CRC16_LENGTH_FRAMED_PACKET_RECEIVER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/plp_pkg.sv
// Package for the CRC-16 length-framed packet receiver.
// Holds field widths, result codes and the per-byte CRC update; no dependencies.
package plp_pkg;

	localparam int MAX_PACKET_LEN_DEF = 4096;
	localparam int HDR_CRC_BYTES = 5;
	localparam int CMP_W = 17;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int IDX_W = 12;
	localparam int STATUS_W = 2;
	localparam int MAXPL_W = 12;

	localparam logic [MAXPL_W-1:0] MAX_PAYLOAD_LEN_RST = 12'd4091;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [KIND_W-1:0] {
		KIND_FRAME_ID = 2'd0,
		KIND_PAYLOAD  = 2'd1,
		KIND_STATUS   = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEN  = 2'd1,
		ST_CRC_ERR  = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	// Bitwise CRC-16 (poly 0x1021, MSB first) over one byte.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

FILE: rtl/plp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
// Depends on plp_pkg for field widths.
interface plp_byte_if import plp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface plp_result_if import plp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [BYTE_W-1:0]   data;
	logic [IDX_W-1:0]    payload_index;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source(output valid, output kind, output data, output payload_index,
		output status, output last, input ready);
	modport sink(input valid, input kind, input data, input payload_index,
		input status, input last, output ready);
endinterface

FILE: rtl/plp_in_stage.sv
// Input register stage for received bytes.
// Depends on plp_pkg and plp_byte_if.
module plp_in_stage import plp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	plp_byte_if.sink   rx,
	plp_byte_if.source s1
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	assign rx.ready = !valid_s1 || s1.ready;
	assign s1.valid = valid_s1;
	assign s1.rx_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

FILE: rtl/plp_parser.sv
// Frame parser: phase tracking, running CRC, length checks and the result register.
// Depends on plp_pkg, plp_byte_if, plp_result_if and the assertion macro header.
`include "crc16_length_framed_packet_receiver_top_defines.svh"

module plp_parser import plp_pkg::*; #(
	parameter int MAX_PACKET_LEN = MAX_PACKET_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [MAXPL_W-1:0] max_payload_len,
	plp_byte_if.sink           s1,
	plp_result_if.source       res
);

	localparam int LW = $clog2(MAX_PACKET_LEN + 1);
	localparam logic [LW-1:0] HDR_L = LW'(HDR_CRC_BYTES);

	typedef enum logic [5:0] {
		PH_LEN_HI   = 6'b000001,
		PH_LEN_LO   = 6'b000010,
		PH_FRAME_ID = 6'b000100,
		PH_PAYLOAD  = 6'b001000,
		PH_CRC_HI   = 6'b010000,
		PH_CRC_LO   = 6'b100000
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [LW-1:0]       frame_len_q, frame_len_d;
	logic [LW-1:0]       byte_count_q, byte_count_d;
	logic [15:0]         crc_q, crc_d;
	logic [7:0]          crc_high_q, crc_high_d;

	logic                out_valid_q;
	kind_t               kind_q, kind_d;
	logic [BYTE_W-1:0]   data_q, data_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	status_t             status_q, status_d;
	logic                last_q, last_d;
	logic                emit_d;

	logic                take;
	logic [15:0]         len16;
	logic [15:0]         crc_base;
	logic [15:0]         crc_upd;
	logic [LW-1:0]       count_inc;
	logic [LW-1:0]       plen;

	assign s1.ready = !out_valid_q || res.ready;
	assign take = s1.valid && s1.ready;

	assign len16 = {crc_high_q, s1.rx_byte};
	assign crc_base = (phase_q == PH_LEN_HI) ? 16'h0000 : crc_q;
	assign crc_upd = crc16_byte(crc_base, s1.rx_byte);
	assign count_inc = byte_count_q + 1'b1;
	assign plen = frame_len_q - HDR_L;

	always_comb begin
		phase_d = phase_q;
		frame_len_d = frame_len_q;
		byte_count_d = byte_count_q;
		crc_d = crc_q;
		crc_high_d = crc_high_q;
		emit_d = 1'b0;
		kind_d = KIND_STATUS;
		data_d = '0;
		idx_d = '0;
		status_d = ST_OK;
		last_d = 1'b0;
		case (phase_q)
			PH_LEN_HI: begin
				crc_d = crc_upd;
				crc_high_d = s1.rx_byte;
				byte_count_d = '0;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				crc_d = crc_upd;
				if (len16 > 16'(MAX_PACKET_LEN) || len16 < 16'(HDR_CRC_BYTES)) begin
					phase_d = PH_LEN_HI;
					frame_len_d = '0;
					emit_d = 1'b1;
					status_d = ST_BAD_LEN;
					last_d = 1'b1;
				end else begin
					frame_len_d = LW'(len16);
					phase_d = PH_FRAME_ID;
				end
			end
			PH_FRAME_ID: begin
				crc_d = crc_upd;
				phase_d = (frame_len_q > HDR_L) ? PH_PAYLOAD : PH_CRC_HI;
				emit_d = 1'b1;
				kind_d = KIND_FRAME_ID;
				data_d = s1.rx_byte;
			end
			PH_PAYLOAD: begin
				crc_d = crc_upd;
				emit_d = 1'b1;
				kind_d = KIND_PAYLOAD;
				data_d = s1.rx_byte;
				idx_d = IDX_W'(byte_count_q);
				byte_count_d = count_inc;
				if (count_inc >= plen) begin
					phase_d = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				crc_high_d = s1.rx_byte;
				phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				phase_d = PH_LEN_HI;
				emit_d = 1'b1;
				last_d = 1'b1;
				if ({crc_high_q, s1.rx_byte} != crc_q) begin
					status_d = ST_CRC_ERR;
				end else if (CMP_W'(plen) > CMP_W'(max_payload_len)) begin
					status_d = ST_TOO_LONG;
				end
			end
			default: begin
				phase_d = PH_LEN_HI;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN_HI;
			frame_len_q <= '0;
			byte_count_q <= '0;
			crc_q <= '0;
			crc_high_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				frame_len_q <= frame_len_d;
				byte_count_q <= byte_count_d;
				crc_q <= crc_d;
				crc_high_q <= crc_high_d;
				out_valid_q <= emit_d;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit_d) begin
			kind_q <= kind_d;
			data_q <= data_d;
			idx_q <= idx_d;
			status_q <= status_d;
			last_q <= last_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.kind = kind_q;
	assign res.data = data_q;
	assign res.payload_index = idx_q;
	assign res.status = status_q;
	assign res.last = last_q;

	`PLP_ASSERT_IMP(a_last_is_status, out_valid_q && last_q, kind_q == KIND_STATUS, "last result is not a status")
	`PLP_ASSERT_NXT(a_payload_emits, take && phase_q == PH_PAYLOAD, out_valid_q && kind_q == KIND_PAYLOAD, "payload byte produced no payload result")
	`PLP_ASSERT_IMP(a_count_in_range, phase_q == PH_PAYLOAD, frame_len_q > HDR_L && byte_count_q < plen, "payload count out of range")
	`PLP_ASSERT_NXT(a_crc_lo_ends, take && phase_q == PH_CRC_LO, phase_q == PH_LEN_HI && out_valid_q && last_q, "frame end did not return to header")

endmodule

FILE: rtl/crc16_length_framed_packet_receiver_top.sv
// Path: an accepted byte is registered in the input stage, then its result in the result register.
// Throughput: one byte per cycle; the byte path only stalls while a result waits to be taken.
// Reset: arst_n is asynchronous, active low; the parser returns to the length high byte,
// counters and CRC clear, and max_payload_len returns to 4091.
// Depends on plp_pkg, plp_if, plp_in_stage and plp_parser.
module crc16_length_framed_packet_receiver_top import plp_pkg::*; #(
	parameter int MAX_PACKET_LEN = MAX_PACKET_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [MAXPL_W-1:0] cfg_wdata,
	plp_byte_if.sink           rx,
	plp_result_if.source       res
);

	logic [MAXPL_W-1:0] max_payload_len_q;

	plp_byte_if s1_ch ();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_len_q <= MAX_PAYLOAD_LEN_RST;
		end else if (cfg_we) begin
			max_payload_len_q <= cfg_wdata;
		end
	end

	plp_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.s1     (s1_ch.source)
	);

	plp_parser #(
		.MAX_PACKET_LEN (MAX_PACKET_LEN)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_payload_len (max_payload_len_q),
		.s1              (s1_ch.sink),
		.res             (res)
	);

endmodule
